/* rtl/pfpc_pkg.sv */
package pfpc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;

    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd500;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic                          partner_valid;
        logic signed [COORD_WIDTH-1:0] partner_x;
        logic signed [COORD_WIDTH-1:0] partner_y;
        logic                          ball_valid;
        logic signed [COORD_WIDTH-1:0] ball_x;
        logic signed [COORD_WIDTH-1:0] ball_y;
    } out_item_t;

    // Command handed from the parser to the cache side
    typedef struct packed {
        logic                        is_read;
        logic                        apply;
        logic [3:0][COORD_WIDTH-1:0] vals;
    } cmd_t;

endpackage

/* rtl/position_frame_parser_cache_unit.sv */
// Channel   | Signals                        | Beat
// ----------+--------------------------------+----------------------------------
// input     | in_valid, in_ready, in_data    | one byte, tick or read request
// output    | out_valid, out_ready, out_data | one position report per read
// config    | cfg_we, cfg_wdata              | cache timeout in ticks, no wait
//
// One beat per cycle while in_ready is high. A read beat enters a two-entry command
// queue at the edge that accepts it; its report is registered once the back end pops it.
// Bytes are parsed at the accepting edge and take no queue entry.
// in_ready drops for every beat once the queue is full, which needs a read held
// behind a report that out_ready has not taken.
// Reset clears the parser, pending frame, cache and ages; timeout goes to 500.
module position_frame_parser_cache_unit #(
    parameter int AGE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pfpc_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pfpc_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [pfpc_pkg::CFG_WIDTH-1:0] cfg_wdata
);

    logic [pfpc_pkg::CFG_WIDTH-1:0] timeout_reg;
    logic                           push, push_ready, pop, pop_valid;
    pfpc_pkg::cmd_t                 push_cmd, pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= pfpc_pkg::TIMEOUT_RESET;
        else if (cfg_we)
            timeout_reg <= cfg_wdata;
    end

    pfpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_push   (push),
        .q_cmd    (push_cmd),
        .q_ready  (push_ready)
    );

    pfpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    pfpc_back #(
        .AGE_WIDTH (AGE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (pop),
        .timeout   (timeout_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/pfpc_front.sv */
module pfpc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfpc_pkg::in_item_t in_data,
    output logic              q_push,
    output pfpc_pkg::cmd_t    q_cmd,
    input  logic              q_ready
);

    localparam int CW    = pfpc_pkg::COORD_WIDTH;
    localparam int WIDEW = CW + 4;
    localparam logic [WIDEW-1:0] MAG_LIMIT = WIDEW'(1) << (CW - 1);

    typedef enum logic [3:0] {
        PH_OUT  = 4'b0001,
        PH_GAP  = 4'b0010,
        PH_SIGN = 4'b0100,
        PH_DIG  = 4'b1000
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [2:0]           cnt_reg, cnt_next, cnt_fin;
    logic [CW-1:0]        acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 failed_reg, failed_next;
    logic [3:0][CW-1:0]   vals_reg, vals_fin;
    logic                 pend_present_reg, pend_present_next;
    logic                 pend_ok_reg, pend_ok_next;
    logic [3:0][CW-1:0]   pend_vals_reg, pend_vals_next;

    logic                 accept;
    logic                 byte_go;
    logic                 is_b, is_e, is_digit, is_space, is_sign;
    logic                 do_finish;
    logic [CW-1:0]        fin_val;
    logic [3:0]           digit;
    logic [WIDEW-1:0]     m_wide;
    logic [7:0]           c;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign byte_go  = accept && (in_data.op == pfpc_pkg::OP_BYTE);
    assign q_push   = accept && ((in_data.op == pfpc_pkg::OP_TICK) ||
                                 (in_data.op == pfpc_pkg::OP_READ));

    assign q_cmd.is_read = (in_data.op == pfpc_pkg::OP_READ);
    assign q_cmd.apply   = pend_present_reg && pend_ok_reg;
    assign q_cmd.vals    = pend_vals_reg;

    assign c        = in_data.rx_byte;
    assign is_b     = (c == pfpc_pkg::CH_B);
    assign is_e     = (c == pfpc_pkg::CH_E);
    assign is_digit = (c >= pfpc_pkg::CH_0) && (c <= pfpc_pkg::CH_9);
    assign is_space = (c == pfpc_pkg::CH_SPACE) ||
                      ((c >= pfpc_pkg::CH_TAB) && (c <= pfpc_pkg::CH_CR));
    assign is_sign  = (c == pfpc_pkg::CH_PLUS) || (c == pfpc_pkg::CH_MINUS);
    assign digit    = 4'(c - pfpc_pkg::CH_0);

    // Magnitude saturates at 2^(CW-1); positive values clamp one below it
    always_comb
    begin
        if (neg_reg)
            fin_val = ~acc_reg + CW'(1);
        else if (acc_reg[CW-1])
            fin_val = {1'b0, {(CW-1){1'b1}}};
        else
            fin_val = acc_reg;
    end

    assign do_finish = byte_go && (phase_reg == PH_DIG) && !is_b &&
                       (is_e || (!failed_reg && (cnt_reg < 3'd4) && !is_digit));
    assign cnt_fin   = cnt_reg + 3'(do_finish);

    always_comb
    begin
        vals_fin = vals_reg;
        if (do_finish && (cnt_reg < 3'd4))
            vals_fin[cnt_reg[1:0]] = fin_val;
    end

    always_comb
    begin
        if (phase_reg == PH_GAP)
            m_wide = WIDEW'(digit);
        else
            m_wide = (WIDEW'(acc_reg) << 3) + (WIDEW'(acc_reg) << 1) + WIDEW'(digit);
    end

    always_comb
    begin
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        failed_next       = failed_reg;
        pend_present_next = pend_present_reg;
        pend_ok_next      = pend_ok_reg;
        pend_vals_next    = pend_vals_reg;

        if (q_push && q_cmd.is_read)
            pend_present_next = 1'b0;

        if (byte_go)
        begin
            if (is_b)
            begin
                phase_next  = PH_GAP;
                cnt_next    = 3'd0;
                acc_next    = '0;
                neg_next    = 1'b0;
                failed_next = 1'b0;
            end
            else if (phase_reg != PH_OUT)
            begin
                if (is_e)
                begin
                    // close the frame: it replaces whatever is pending
                    cnt_next          = cnt_fin;
                    pend_present_next = 1'b1;
                    pend_ok_next      = !failed_reg && (cnt_fin >= 3'd4);
                    pend_vals_next    = vals_fin;
                    phase_next        = PH_OUT;
                    if (do_finish)
                    begin
                        acc_next = '0;
                        neg_next = 1'b0;
                    end
                end
                else if (!failed_reg && (cnt_reg < 3'd4))
                begin
                    if (is_digit)
                    begin
                        if (phase_reg == PH_GAP)
                            neg_next = 1'b0;
                        acc_next   = (m_wide > MAG_LIMIT) ? MAG_LIMIT[CW-1:0]
                                                          : m_wide[CW-1:0];
                        phase_next = PH_DIG;
                    end
                    else if (phase_reg == PH_SIGN)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (do_finish)
                        begin
                            cnt_next   = cnt_fin;
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            phase_next = PH_GAP;
                        end
                        if (cnt_fin < 3'd4)
                        begin
                            if (is_sign)
                            begin
                                acc_next   = '0;
                                neg_next   = (c == pfpc_pkg::CH_MINUS);
                                phase_next = PH_SIGN;
                            end
                            else if (!is_space)
                            begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OUT;
            cnt_reg          <= '0;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            failed_reg       <= 1'b0;
            vals_reg         <= '0;
            pend_present_reg <= 1'b0;
            pend_ok_reg      <= 1'b0;
            pend_vals_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            acc_reg          <= acc_next;
            neg_reg          <= neg_next;
            failed_reg       <= failed_next;
            vals_reg         <= vals_fin;
            pend_present_reg <= pend_present_next;
            pend_ok_reg      <= pend_ok_next;
            pend_vals_reg    <= pend_vals_next;
        end
    end

endmodule

/* rtl/pfpc_queue.sv */
module pfpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pfpc_pkg::cmd_t push_cmd,
    output logic           push_ready,
    input  logic           pop,
    output pfpc_pkg::cmd_t pop_cmd,
    output logic           pop_valid
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfpc_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/pfpc_back.sv */
module pfpc_back #(
    parameter int AGE_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  pfpc_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    input  logic [pfpc_pkg::CFG_WIDTH-1:0]  timeout,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pfpc_pkg::out_item_t             out_data
);

    localparam int CW    = pfpc_pkg::COORD_WIDTH;
    localparam int CMP_W = (AGE_WIDTH > pfpc_pkg::CFG_WIDTH) ? AGE_WIDTH
                                                             : pfpc_pkg::CFG_WIDTH;

    logic                   p_valid_reg, p_valid_next;
    logic                   b_valid_reg, b_valid_next;
    logic [1:0][CW-1:0]     p_xy_reg, p_xy_next;
    logic [1:0][CW-1:0]     b_xy_reg, b_xy_next;
    logic [AGE_WIDTH-1:0]   p_age_reg, p_age_next;
    logic [AGE_WIDTH-1:0]   b_age_reg, b_age_next;
    logic                   out_valid_reg, out_valid_next;
    pfpc_pkg::out_item_t    out_data_reg, out_data_next;

    logic                   take, tick_go, read_go;
    logic                   p_fresh, b_fresh, pv, bv;

    assign take    = q_valid && (!q_cmd.is_read || !out_valid_reg || out_ready);
    assign q_pop   = take;
    assign tick_go = take && !q_cmd.is_read;
    assign read_go = take && q_cmd.is_read;

    assign p_fresh = q_cmd.apply && (q_cmd.vals[0] != '0) && (q_cmd.vals[1] != '0);
    assign b_fresh = q_cmd.apply && (q_cmd.vals[2] != '0) && (q_cmd.vals[3] != '0);

    always_comb
    begin
        p_valid_next = p_valid_reg;
        b_valid_next = b_valid_reg;
        p_xy_next    = p_xy_reg;
        b_xy_next    = b_xy_reg;
        p_age_next   = p_age_reg;
        b_age_next   = b_age_reg;

        if (tick_go)
        begin
            // saturate ages at all ones
            if (p_age_reg != '1)
                p_age_next = p_age_reg + AGE_WIDTH'(1);
            if (b_age_reg != '1)
                b_age_next = b_age_reg + AGE_WIDTH'(1);
        end

        if (read_go && p_fresh)
        begin
            p_valid_next = 1'b1;
            p_xy_next    = {q_cmd.vals[1], q_cmd.vals[0]};
            p_age_next   = '0;
        end
        if (read_go && b_fresh)
        begin
            b_valid_next = 1'b1;
            b_xy_next    = {q_cmd.vals[3], q_cmd.vals[2]};
            b_age_next   = '0;
        end
    end

    assign pv = p_valid_next && (CMP_W'(p_age_next) <= CMP_W'(timeout));
    assign bv = b_valid_next && (CMP_W'(b_age_next) <= CMP_W'(timeout));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (read_go)
        begin
            out_valid_next              = 1'b1;
            out_data_next.partner_valid = pv;
            out_data_next.partner_x     = pv ? p_xy_next[0] : '0;
            out_data_next.partner_y     = pv ? p_xy_next[1] : '0;
            out_data_next.ball_valid    = bv;
            out_data_next.ball_x        = bv ? b_xy_next[0] : '0;
            out_data_next.ball_y        = bv ? b_xy_next[1] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        p_xy_reg     <= p_xy_next;
        b_xy_reg     <= b_xy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            p_age_reg     <= '0;
            b_age_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            b_valid_reg   <= b_valid_next;
            p_age_reg     <= p_age_next;
            b_age_reg     <= b_age_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
